[sv/bsrq_pkg.sv]
// Shared types, constants and pointer helpers for the batched SPSC ring queue.
package bsrq_pkg;

    localparam int RING_DEPTH = 64;
    localparam int WORD_WIDTH = 64;
    localparam int SLOT_W     = $clog2(RING_DEPTH);
    localparam int DIST_W     = SLOT_W + 1;
    localparam int COUNT_W    = 6;
    localparam int BATCH_W    = 6;
    localparam int DATA_W     = 64;
    localparam int CMD_W      = 2;

    localparam logic [BATCH_W-1:0] BATCH_RESET = BATCH_W'(4);

    localparam logic [CMD_W-1:0] CMD_PRODUCE = 2'd0;
    localparam logic [CMD_W-1:0] CMD_CONSUME = 2'd1;
    localparam logic [CMD_W-1:0] CMD_FLUSH   = 2'd2;

    typedef logic [SLOT_W-1:0]     t_slot;
    typedef logic [DIST_W-1:0]     t_dist;
    typedef logic [COUNT_W-1:0]    t_count;
    typedef logic [BATCH_W-1:0]    t_batch;
    typedef logic [WORD_WIDTH-1:0] t_word;

    typedef struct packed {
        logic [CMD_W-1:0]  command;
        logic [DATA_W-1:0] write_data;
    } t_cmd_in;

    typedef struct packed {
        logic              accepted;
        logic [DATA_W-1:0] read_data;
        t_count            unpublished_count;
        t_count            readable_count;
    } t_result;

    // Next slot round the ring; depth need not be a power of two.
    function automatic t_slot slot_after(input t_slot s);
        t_slot r;
        if (s == SLOT_W'(RING_DEPTH - 1)) begin
            r = '0;
        end else begin
            r = s + 1'b1;
        end
        return r;
    endfunction

    // Forward distance from one slot to another, modulo the depth.
    function automatic t_dist ring_dist(input t_slot from_s, input t_slot to_s);
        t_dist f;
        t_dist t;
        t_dist r;
        f = {1'b0, from_s};
        t = {1'b0, to_s};
        if (t >= f) begin
            r = t - f;
        end else begin
            r = t + DIST_W'(RING_DEPTH) - f;
        end
        return r;
    endfunction

endpackage

[sv/bsrq_ram.sv]
// Ring storage: one write port, one read port, registered read data.
module bsrq_ram (
    input  logic              i_clk,
    input  logic              i_we,
    input  bsrq_pkg::t_slot   i_waddr,
    input  bsrq_pkg::t_word   i_wdata,
    input  logic              i_re,
    input  bsrq_pkg::t_slot   i_raddr,
    output bsrq_pkg::t_word   o_rdata
);

    bsrq_pkg::t_word mem [bsrq_pkg::RING_DEPTH];
    bsrq_pkg::t_word r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[sv/batched_spsc_ring_queue.sv]
// Top level of the batched single-producer single-consumer ring queue.
//
// Usage:
//   Command channel: present i_cmd and raise start; the command is taken at
//   a rising edge where start is high and busy is low. Commands are produce
//   (store write_data), consume (take the oldest published word) and flush
//   (publish the producer position at once).
//   Result channel: o_valid strobes for one cycle with o_result, in the
//   cycle after the command was taken. The receiver cannot stall; it must
//   take every word as it goes by.
//   Throughput: one command per cycle while busy is low. The storage read
//   port is registered, which puts the result in the cycle after the command;
//   pointers and batch counters are updated in the same cycle the command is taken.
//   Configuration: i_cfg_we writes batch_size from i_cfg_wdata; write it
//   only while no result is outstanding.
//   Reset: synchronous, active low. All pointers and counters clear, batch
//   size returns to 4, and busy stays high until the first clock edge after reset
//   is released. Storage is not cleared: only published, written slots are
//   ever read.
module batched_spsc_ring_queue (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         start,
    output logic                         busy,
    input  bsrq_pkg::t_cmd_in            i_cmd,
    output logic                         o_valid,
    output bsrq_pkg::t_result            o_result,
    input  logic                         i_cfg_we,
    input  logic [bsrq_pkg::BATCH_W-1:0] i_cfg_wdata
);

    // Producer side state
    bsrq_pkg::t_slot  r_pnext, n_pnext;   // next slot to write
    bsrq_pkg::t_slot  r_pcopy, n_pcopy;   // producer's copy of read position
    bsrq_pkg::t_batch r_pcnt,  n_pcnt;    // produces since last publish
    bsrq_pkg::t_slot  r_pubw,  n_pubw;    // published write position
    // Consumer side state
    bsrq_pkg::t_slot  r_cnext, n_cnext;   // next slot to read
    bsrq_pkg::t_slot  r_ccopy, n_ccopy;   // consumer's copy of write position
    bsrq_pkg::t_batch r_ccnt,  n_ccnt;    // consumes since last publish
    bsrq_pkg::t_slot  r_pubr,  n_pubr;    // published read position

    bsrq_pkg::t_batch r_batch;
    logic             r_busy;

    // Result registers; read data joins from the storage output register
    logic             r_valid;
    logic             r_acc,   n_acc;
    logic             r_rd,    n_rd;
    bsrq_pkg::t_count r_unpub, n_unpub;
    bsrq_pkg::t_count r_rdbl,  n_rdbl;

    logic             take;
    logic             mem_we;
    logic             mem_re;
    bsrq_pkg::t_word  mem_q;
    bsrq_pkg::t_slot  p_after;
    bsrq_pkg::t_batch p_inc;
    bsrq_pkg::t_batch c_inc;
    logic             full;
    logic             empty;

    assign take = start & ~busy;
    assign busy = r_busy;

    bsrq_ram u_ram (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (r_pnext),
        .i_wdata (i_cmd.write_data[bsrq_pkg::WORD_WIDTH-1:0]),
        .i_re    (mem_re),
        .i_raddr (r_cnext),
        .o_rdata (mem_q)
    );

    // Command decode and pointer update
    always_comb begin
        n_pnext = r_pnext;
        n_pcopy = r_pcopy;
        n_pcnt  = r_pcnt;
        n_pubw  = r_pubw;
        n_cnext = r_cnext;
        n_ccopy = r_ccopy;
        n_ccnt  = r_ccnt;
        n_pubr  = r_pubr;
        n_acc   = 1'b0;
        n_rd    = 1'b0;
        mem_we  = 1'b0;
        mem_re  = 1'b0;
        full    = 1'b0;
        empty   = 1'b0;
        p_after = bsrq_pkg::slot_after(r_pnext);
        p_inc   = r_pcnt + 1'b1;
        c_inc   = r_ccnt + 1'b1;

        if (take) begin
            case (i_cmd.command)
                bsrq_pkg::CMD_PRODUCE: begin
                    // Refresh the read copy only when it claims full
                    if (p_after == r_pcopy) begin
                        if (p_after == r_pubr) begin
                            full = 1'b1;
                        end else begin
                            n_pcopy = r_pubr;
                        end
                    end
                    if (!full) begin
                        mem_we  = 1'b1;
                        n_pnext = p_after;
                        n_acc   = 1'b1;
                        if (p_inc >= r_batch) begin
                            n_pubw = p_after;
                            n_pcnt = '0;
                        end else begin
                            n_pcnt = p_inc;
                        end
                    end
                end
                bsrq_pkg::CMD_CONSUME: begin
                    if (r_cnext == r_ccopy) begin
                        if (r_cnext == r_pubw) begin
                            empty = 1'b1;
                        end else begin
                            n_ccopy = r_pubw;
                        end
                    end
                    if (!empty) begin
                        mem_re  = 1'b1;
                        n_rd    = 1'b1;
                        n_cnext = bsrq_pkg::slot_after(r_cnext);
                        n_acc   = 1'b1;
                        if (c_inc >= r_batch) begin
                            n_pubr = n_cnext;
                            n_ccnt = '0;
                        end else begin
                            n_ccnt = c_inc;
                        end
                    end
                end
                bsrq_pkg::CMD_FLUSH: begin
                    n_pubw = r_pnext;
                    n_pcnt = '0;
                    n_acc  = 1'b1;
                end
                default: begin
                    // unused code: no change, not accepted
                end
            endcase
        end

        n_unpub = bsrq_pkg::COUNT_W'(bsrq_pkg::ring_dist(n_pubw, n_pnext));
        n_rdbl  = bsrq_pkg::COUNT_W'(bsrq_pkg::ring_dist(n_cnext, n_pubw));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pnext <= '0;
            r_pcopy <= '0;
            r_pcnt  <= '0;
            r_pubw  <= '0;
            r_cnext <= '0;
            r_ccopy <= '0;
            r_ccnt  <= '0;
            r_pubr  <= '0;
            r_batch <= bsrq_pkg::BATCH_RESET;
            r_busy  <= 1'b1;
            r_valid <= 1'b0;
            r_acc   <= 1'b0;
            r_rd    <= 1'b0;
        end else begin
            r_pnext <= n_pnext;
            r_pcopy <= n_pcopy;
            r_pcnt  <= n_pcnt;
            r_pubw  <= n_pubw;
            r_cnext <= n_cnext;
            r_ccopy <= n_ccopy;
            r_ccnt  <= n_ccnt;
            r_pubr  <= n_pubr;
            if (i_cfg_we) begin
                r_batch <= i_cfg_wdata;
            end
            r_busy  <= 1'b0;
            r_valid <= take;
            r_acc   <= n_acc;
            r_rd    <= n_rd;
        end
    end

    // Count fields are payload: no reset needed
    always_ff @(posedge i_clk) begin
        r_unpub <= n_unpub;
        r_rdbl  <= n_rdbl;
    end

    assign o_valid                    = r_valid;
    assign o_result.accepted          = r_acc;
    assign o_result.read_data         = r_rd ? bsrq_pkg::DATA_W'(mem_q) : '0;
    assign o_result.unpublished_count = r_unpub;
    assign o_result.readable_count    = r_rdbl;

    // Every taken command yields exactly one result word, the next cycle
    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        take |=> o_valid)
        else $error("result strobe missing after a taken command");

    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !take |=> !o_valid)
        else $error("result strobe without a taken command");

    // Consumer never runs past the producer, and one slot always stays free
    a_occupancy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (32'(bsrq_pkg::ring_dist(r_cnext, r_pubw))
            + 32'(bsrq_pkg::ring_dist(r_pubw, r_pnext))) < 32'(bsrq_pkg::RING_DEPTH))
        else $error("ring pointers out of order");

    // Storage is read only for a successful consume
    a_read_gated: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mem_re |-> (take && (i_cmd.command == bsrq_pkg::CMD_CONSUME) && !empty))
        else $error("storage read outside a successful consume");

endmodule

[sim/testbench.sv]
// Self-checking testbench for the batched SPSC ring queue: directed table, then random phases.
`timescale 1ns / 1ps

module testbench;

    // Command code the block does not define: it must leave all state alone.
    localparam logic [bsrq_pkg::CMD_W-1:0] CMD_UNUSED = 2'd3;

    typedef enum logic {ROW_CMD, ROW_CFG} t_row_kind;
    typedef enum logic [1:0] {MIX_FILL, MIX_DRAIN, MIX_EVEN} t_mix;

    // One row of the directed table. A ROW_CFG row writes data[5:0] to batch_size.
    // Where fixed is set, want is the reply word typed in by hand.
    typedef struct {
        t_row_kind                      kind;
        logic [bsrq_pkg::CMD_W-1:0]     command;
        logic [bsrq_pkg::DATA_W-1:0]    data;
        bit                             fixed;
        bsrq_pkg::t_result              want;
    } t_row;

    logic                   clk = 1'b0;
    logic                   rst_n;
    logic                   start;
    logic                   busy;
    bsrq_pkg::t_cmd_in      cmd_word;
    logic                   result_valid;
    bsrq_pkg::t_result      result_word;
    logic                   cfg_we;
    bsrq_pkg::t_batch       cfg_wdata;

    // Travel alongside cmd_word: a hand-typed reply for directed rows.
    bit                     row_fixed;
    bsrq_pkg::t_result      row_fixed_result;

    // Predictor state. Slots are SLOT_W bits and the depth is 2**SLOT_W, so
    // stepping round the ring and ring distances are plain modular arithmetic.
    bsrq_pkg::t_word        ring_words [bsrq_pkg::RING_DEPTH];
    bsrq_pkg::t_slot        prod_slot;
    bsrq_pkg::t_slot        prod_seen_rd;     // producer's private copy of the read slot
    bsrq_pkg::t_batch       prod_batch;
    bsrq_pkg::t_slot        pub_wr;           // write slot as the consumer sees it
    bsrq_pkg::t_slot        cons_slot;
    bsrq_pkg::t_slot        cons_seen_wr;     // consumer's private copy of the write slot
    bsrq_pkg::t_batch       cons_batch;
    bsrq_pkg::t_slot        pub_rd;           // read slot as the producer sees it
    bsrq_pkg::t_batch       batch_limit;

    bsrq_pkg::t_result      replies_due [$];
    int                     mismatches = 0;

    t_row directed_rows [24] = '{
        // empty after reset, and the unused code: nothing moves
        '{ROW_CMD, bsrq_pkg::CMD_CONSUME, 64'h0, 1'b1, '{1'b0, 64'h0, 6'd0, 6'd0}},
        '{ROW_CMD, CMD_UNUSED, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1, '{1'b0, 64'h0, 6'd0, 6'd0}},
        // two words held back by the batch of four, then flushed
        '{ROW_CMD, bsrq_pkg::CMD_PRODUCE, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1,
          '{1'b1, 64'h0, 6'd1, 6'd0}},
        '{ROW_CMD, bsrq_pkg::CMD_PRODUCE, 64'h0, 1'b1, '{1'b1, 64'h0, 6'd2, 6'd0}},
        '{ROW_CMD, bsrq_pkg::CMD_FLUSH, 64'h0, 1'b1, '{1'b1, 64'h0, 6'd0, 6'd2}},
        '{ROW_CMD, bsrq_pkg::CMD_CONSUME, 64'h0, 1'b1,
          '{1'b1, 64'hFFFF_FFFF_FFFF_FFFF, 6'd0, 6'd1}},
        '{ROW_CMD, bsrq_pkg::CMD_CONSUME, 64'h0, 1'b1, '{1'b1, 64'h0, 6'd0, 6'd0}},
        '{ROW_CMD, bsrq_pkg::CMD_CONSUME, 64'h0, 1'b1, '{1'b0, 64'h0, 6'd0, 6'd0}},
        // batch size lowered mid-batch: the next produce publishes
        '{ROW_CMD, bsrq_pkg::CMD_PRODUCE, 64'hAAAA_AAAA_AAAA_AAAA, 1'b0, '0},
        '{ROW_CMD, bsrq_pkg::CMD_PRODUCE, 64'h5555_5555_5555_5555, 1'b0, '0},
        '{ROW_CFG, CMD_UNUSED, 64'd1, 1'b0, '0},
        '{ROW_CMD, bsrq_pkg::CMD_PRODUCE, 64'h8000_0000_0000_0001, 1'b0, '0},
        '{ROW_CMD, bsrq_pkg::CMD_CONSUME, 64'h0, 1'b0, '0},
        '{ROW_CMD, bsrq_pkg::CMD_CONSUME, 64'h0, 1'b0, '0},
        '{ROW_CMD, bsrq_pkg::CMD_CONSUME, 64'h0, 1'b0, '0},
        // batch size zero: every operation publishes at once
        '{ROW_CFG, CMD_UNUSED, 64'd0, 1'b0, '0},
        '{ROW_CMD, bsrq_pkg::CMD_PRODUCE, 64'h0123_4567_89AB_CDEF, 1'b0, '0},
        '{ROW_CMD, bsrq_pkg::CMD_CONSUME, 64'h0, 1'b0, '0},
        '{ROW_CMD, CMD_UNUSED, 64'h0, 1'b0, '0},
        // largest batch: only the flush makes the word visible
        '{ROW_CFG, CMD_UNUSED, 64'd63, 1'b0, '0},
        '{ROW_CMD, bsrq_pkg::CMD_PRODUCE, 64'hFEDC_BA98_7654_3210, 1'b0, '0},
        '{ROW_CMD, bsrq_pkg::CMD_FLUSH, 64'h0, 1'b0, '0},
        '{ROW_CMD, bsrq_pkg::CMD_CONSUME, 64'h0, 1'b0, '0},
        '{ROW_CFG, CMD_UNUSED, 64'd4, 1'b0, '0}
    };

    batched_spsc_ring_queue uut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .start       (start),
        .busy        (busy),
        .i_cmd       (cmd_word),
        .o_valid     (result_valid),
        .o_result    (result_word),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata)
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Applies one command word to the predictor state and returns the reply.
    function automatic bsrq_pkg::t_result ring_queue_reply(input bsrq_pkg::t_cmd_in w);
        bsrq_pkg::t_result r;
        bsrq_pkg::t_slot   nxt;
        bit                blocked;
        r = '0;
        blocked = 1'b0;
        case (w.command)
            bsrq_pkg::CMD_PRODUCE: begin
                nxt = prod_slot + 1'b1;
                // Full by the private copy: look at the published read slot once.
                if (nxt == prod_seen_rd) begin
                    if (nxt == pub_rd) begin
                        blocked = 1'b1;
                    end else begin
                        prod_seen_rd = pub_rd;
                    end
                end
                if (!blocked) begin
                    ring_words[prod_slot] = w.write_data;
                    prod_slot = nxt;
                    prod_batch = prod_batch + 1'b1;
                    if (prod_batch >= batch_limit) begin
                        pub_wr = prod_slot;
                        prod_batch = '0;
                    end
                    r.accepted = 1'b1;
                end
            end
            bsrq_pkg::CMD_CONSUME: begin
                if (cons_slot == cons_seen_wr) begin
                    if (cons_slot == pub_wr) begin
                        blocked = 1'b1;
                    end else begin
                        cons_seen_wr = pub_wr;
                    end
                end
                if (!blocked) begin
                    r.read_data = ring_words[cons_slot];
                    cons_slot = cons_slot + 1'b1;
                    cons_batch = cons_batch + 1'b1;
                    if (cons_batch >= batch_limit) begin
                        pub_rd = cons_slot;
                        cons_batch = '0;
                    end
                    r.accepted = 1'b1;
                end
            end
            bsrq_pkg::CMD_FLUSH: begin
                pub_wr = prod_slot;
                prod_batch = '0;
                r.accepted = 1'b1;
            end
            default: begin
            end
        endcase
        r.unpublished_count = bsrq_pkg::t_count'(prod_slot - pub_wr);
        r.readable_count    = bsrq_pkg::t_count'(pub_wr - cons_slot);
        return r;
    endfunction

    task automatic flag_field(input string name,
                              input logic [bsrq_pkg::DATA_W-1:0] want,
                              input logic [bsrq_pkg::DATA_W-1:0] got);
        $display("%0t: %s expected %h got %h", $time, name, want, got);
        mismatches++;
    endtask

    // Scoreboard. Everything is sampled at the rising edge, before the block's
    // own updates land: the reply strobe is checked first, then a batch_size
    // write and a taken command word update the predictor.
    always @(posedge clk) begin
        bsrq_pkg::t_result want;
        if (!rst_n) begin
            prod_slot    = '0;
            prod_seen_rd = '0;
            prod_batch   = '0;
            pub_wr       = '0;
            cons_slot    = '0;
            cons_seen_wr = '0;
            cons_batch   = '0;
            pub_rd       = '0;
            batch_limit  = bsrq_pkg::BATCH_RESET;
        end else begin
            if (result_valid === 1'b1) begin
                if (replies_due.size() == 0) begin
                    $display("%0t: reply word with none due: %h", $time, result_word);
                    mismatches++;
                end else begin
                    want = replies_due.pop_front();
                    if (result_word.accepted !== want.accepted)
                        flag_field("accepted", bsrq_pkg::DATA_W'(want.accepted),
                                   bsrq_pkg::DATA_W'(result_word.accepted));
                    if (result_word.read_data !== want.read_data)
                        flag_field("read_data", want.read_data, result_word.read_data);
                    if (result_word.unpublished_count !== want.unpublished_count)
                        flag_field("unpublished_count",
                                   bsrq_pkg::DATA_W'(want.unpublished_count),
                                   bsrq_pkg::DATA_W'(result_word.unpublished_count));
                    if (result_word.readable_count !== want.readable_count)
                        flag_field("readable_count",
                                   bsrq_pkg::DATA_W'(want.readable_count),
                                   bsrq_pkg::DATA_W'(result_word.readable_count));
                end
            end
            if (cfg_we) begin
                batch_limit = cfg_wdata;
            end
            if (start && busy === 1'b0) begin
                want = ring_queue_reply(cmd_word);
                if (row_fixed) begin
                    want = row_fixed_result;
                end
                replies_due.push_back(want);
            end
        end
    end

    // Hands one command word over; returns at the edge that takes it, with
    // start still high so back-to-back words need no gap.
    task automatic send_word(input logic [bsrq_pkg::CMD_W-1:0] c,
                             input logic [bsrq_pkg::DATA_W-1:0] d,
                             input bit fixed, input bsrq_pkg::t_result want);
        cmd_word         <= '{command: c, write_data: d};
        row_fixed        <= fixed;
        row_fixed_result <= want;
        start            <= 1'b1;
        @(posedge clk);
        while (busy !== 1'b0) @(posedge clk);
    endtask

    // Stop sending and wait until every reply is in, then idle before returning.
    // Any reply still due when the wait runs out is flagged and dropped.
    task automatic await_replies();
        int waited;
        waited = 0;
        start <= 1'b0;
        @(posedge clk);
        while (replies_due.size() != 0 && waited < 64) begin
            @(posedge clk);
            waited++;
        end
        if (replies_due.size() != 0) begin
            $display("%0t: %0d reply words never arrived", $time, replies_due.size());
            mismatches++;
            replies_due.delete();
        end
        repeat (2) @(posedge clk);
    endtask

    // batch_size only changes with the queue quiet.
    task automatic program_batch(input bsrq_pkg::t_batch size);
        await_replies();
        cfg_we    <= 1'b1;
        cfg_wdata <= size;
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    task automatic idle_burst();
        start <= 1'b0;
        repeat ($urandom_range(1, 13)) @(posedge clk);
    endtask

    function automatic logic [bsrq_pkg::DATA_W-1:0] random_word();
        logic [bsrq_pkg::DATA_W-1:0] w;
        case ($urandom_range(0, 7))
            0: w = '0;
            1: w = '1;
            default: w = {$urandom, $urandom};
        endcase
        return w;
    endfunction

    // Mostly produce, mostly consume or an even mix; in long runs the ring fills to
    // full and drains to empty; flushes and the unused code sprinkled in.
    function automatic logic [bsrq_pkg::CMD_W-1:0] random_command(input t_mix mix);
        int unsigned r;
        logic [bsrq_pkg::CMD_W-1:0] c;
        r = $urandom_range(0, 99);
        if (r < 2) begin
            c = CMD_UNUSED;
        end else if (r < 7) begin
            c = bsrq_pkg::CMD_FLUSH;
        end else begin
            case (mix)
                MIX_FILL:  c = (r < 82) ? bsrq_pkg::CMD_PRODUCE : bsrq_pkg::CMD_CONSUME;
                MIX_DRAIN: c = (r < 82) ? bsrq_pkg::CMD_CONSUME : bsrq_pkg::CMD_PRODUCE;
                default:   c = (r < 53) ? bsrq_pkg::CMD_PRODUCE : bsrq_pkg::CMD_CONSUME;
            endcase
        end
        return c;
    endfunction

    initial begin
        int               i;
        int               ph;
        int               k;
        int               run_left;
        t_mix             mix;
        bit               idle_on;
        bit               stretch_idle;
        bsrq_pkg::t_batch size;

        rst_n            <= 1'b0;
        start            <= 1'b0;
        cmd_word         <= '0;
        cfg_we           <= 1'b0;
        cfg_wdata        <= '0;
        row_fixed        <= 1'b0;
        row_fixed_result <= '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // Directed table, batch_size at its reset value to begin with.
        for (i = 0; i < $size(directed_rows); i++) begin
            if (directed_rows[i].kind == ROW_CFG) begin
                program_batch(directed_rows[i].data[bsrq_pkg::BATCH_W-1:0]);
            end else begin
                send_word(directed_rows[i].command, directed_rows[i].data,
                          directed_rows[i].fixed, directed_rows[i].want);
            end
        end

        // Random phases, each with its own batch_size; the extremes come first.
        // Each batch_size write first waits for every outstanding reply. The last
        // phase runs flat out with no idling at all.
        for (ph = 0; ph < 13; ph++) begin
            case (ph)
                0:       size = bsrq_pkg::t_batch'(63);
                1:       size = bsrq_pkg::t_batch'(0);
                2:       size = bsrq_pkg::t_batch'(1);
                default: size = bsrq_pkg::t_batch'($urandom_range(0, 63));
            endcase
            program_batch(size);
            idle_on = (ph != 12);
            run_left = 0;
            mix = MIX_EVEN;
            stretch_idle = 1'b0;
            for (k = 0; k < 145; k++) begin
                if (run_left == 0) begin
                    run_left = $urandom_range(10, 90);
                    mix = t_mix'($urandom_range(0, 2));
                    stretch_idle = ($urandom_range(0, 3) != 0);
                end
                run_left--;
                if (idle_on && stretch_idle && $urandom_range(0, 5) == 0) begin
                    idle_burst();
                end
                send_word(random_command(mix), random_word(), 1'b0, '0);
            end
        end

        await_replies();
        repeat (4) @(posedge clk);
        if (mismatches == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

    // Watchdog: far beyond the slowest correct run.
    initial begin
        #3_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
